// ===== design/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Shared configuration codes and the command/status bundles that join the
// scheduler controller to its datapath.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CFG_DISK_SIZE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEAD_START   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIRECTION_UP = 2'd2;

  localparam logic [16:0] DISK_SIZE_RST    = 17'd200;
  localparam logic [15:0] HEAD_START_RST   = 16'd0;
  localparam logic        DIRECTION_UP_RST = 1'b1;

  typedef enum logic [2:0] {
    PTR_HOLD  = 3'd0,
    PTR_CNT   = 3'd1,
    PTR_ZERO  = 3'd2,
    PTR_INC   = 3'd3,
    PTR_DEC   = 3'd4,
    PTR_SPLIT = 3'd5
  } ptr_op_e;

  typedef enum logic [1:0] {
    VIS_START = 2'd0,
    VIS_DATA  = 2'd1,
    VIS_EDGE  = 2'd2
  } vis_sel_e;

  typedef struct packed {
    logic     capture;
    logic     rd_en;
    logic     rd_prev;
    logic     wr_shift;
    logic     wr_req;
    ptr_op_e  ptr_op;
    logic     save_split;
    logic     vis_en;
    vis_sel_e vis_sel;
    logic     vis_last;
    logic     clr_count;
  } dp_cmd_t;

  typedef struct packed {
    logic dir_up;
    logic full;
    logic ptr_zero;
    logic ptr_one;
    logic ptr_eq_cnt;
    logic ptr_eq_cnt_m1;
    logic gt_req;
    logic gt_start;
    logic split_zero;
    logic split_eq_cnt;
    logic slot_free;
  } dp_sts_t;

endpackage

// ===== design/sds_datapath.sv =====
// ----------------------------------------------------------------------------
// SCAN disk scheduler datapath
// Configuration registers, sorted request memory, pointers, head position,
// saturating movement accumulator and the output word register.
// ----------------------------------------------------------------------------
module sds_datapath import sds_pkg::*; #(
  parameter int MAX_REQUESTS = 32,
  parameter int CYL_BITS     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [CYL_BITS-1:0] req_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CYL_BITS-1:0] out_pos_o,
  output logic [CYL_BITS:0]   out_sum_o,
  output logic                out_last_o
);

  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int EW = (CYL_BITS + 1 > 17) ? CYL_BITS + 1 : 17;
  localparam logic [CYL_BITS-1:0] CylMask = {CYL_BITS{1'b1}};
  localparam logic [CYL_BITS+1:0] MoveMax = {1'b0, {(CYL_BITS + 1){1'b1}}};

  logic [16:0]         disk_size_q;
  logic [15:0]         head_start_q;
  logic                dir_up_q;

  logic [CYL_BITS-1:0] mem [MAX_REQUESTS];
  logic [CYL_BITS-1:0] rd_data_q;
  logic [CYL_BITS-1:0] req_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       split_q;
  logic [CYL_BITS-1:0] head_q;
  logic [CYL_BITS:0]   sum_q;
  logic                out_valid_q;
  logic                out_last_q;

  logic [CW-1:0]       ptr_m1;
  logic [AW-1:0]       rd_addr;
  logic [CYL_BITS-1:0] start_pos;
  logic [EW-1:0]       size_ext;
  logic [CYL_BITS-1:0] edge_hi;
  logic [CYL_BITS-1:0] vis_pos;
  logic [CYL_BITS-1:0] move_dist;
  logic [CYL_BITS+1:0] sum_ext;
  logic [CYL_BITS:0]   sum_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_size_q  <= DISK_SIZE_RST;
      head_start_q <= HEAD_START_RST;
      dir_up_q     <= DIRECTION_UP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DISK_SIZE:    disk_size_q  <= cfg_data_i;
        CFG_HEAD_START:   head_start_q <= cfg_data_i[15:0];
        CFG_DIRECTION_UP: dir_up_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ptr_m1  = ptr_q - CW'(1);
  assign rd_addr = cmd_i.rd_prev ? ptr_m1[AW-1:0] : ptr_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_shift) begin
      mem[ptr_q[AW-1:0]] <= rd_data_q;
    end else if (cmd_i.wr_req) begin
      mem[ptr_q[AW-1:0]] <= req_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.save_split) begin
      split_q <= ptr_q;
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_op)
      PTR_CNT:   ptr_d = count_q;
      PTR_ZERO:  ptr_d = '0;
      PTR_INC:   ptr_d = ptr_q + CW'(1);
      PTR_DEC:   ptr_d = ptr_m1;
      PTR_SPLIT: ptr_d = split_q;
      default:   ptr_d = ptr_q;
    endcase
  end

  assign start_pos = CYL_BITS'(head_start_q);
  assign size_ext  = EW'(disk_size_q);

  always_comb begin
    if (size_ext == '0) begin
      edge_hi = '0;
    end else if (size_ext > EW'(CylMask)) begin
      edge_hi = CylMask;
    end else begin
      edge_hi = CYL_BITS'(size_ext - EW'(1));
    end
  end

  always_comb begin
    unique case (cmd_i.vis_sel)
      VIS_START: vis_pos = start_pos;
      VIS_EDGE:  vis_pos = dir_up_q ? edge_hi : '0;
      default:   vis_pos = rd_data_q;
    endcase
  end

  assign move_dist = (vis_pos > head_q) ? vis_pos - head_q : head_q - vis_pos;
  assign sum_ext   = {1'b0, sum_q} + (CYL_BITS + 2)'(move_dist);
  assign sum_next  = (sum_ext > MoveMax) ? MoveMax[CYL_BITS:0] : sum_ext[CYL_BITS:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      head_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.clr_count) begin
        count_q <= '0;
      end else if (cmd_i.wr_req) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.vis_en) begin
        head_q      <= vis_pos;
        sum_q       <= (cmd_i.vis_sel == VIS_START) ? '0 : sum_next;
        out_valid_q <= 1'b1;
        out_last_q  <= cmd_i.vis_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.dir_up        = dir_up_q;
  assign sts_o.full          = (count_q == CW'(MAX_REQUESTS));
  assign sts_o.ptr_zero      = (ptr_q == '0);
  assign sts_o.ptr_one       = (ptr_q == CW'(1));
  assign sts_o.ptr_eq_cnt    = (ptr_q == count_q);
  assign sts_o.ptr_eq_cnt_m1 = (({1'b0, ptr_q} + (CW + 1)'(1)) == {1'b0, count_q});
  assign sts_o.gt_req        = (rd_data_q > req_q);
  assign sts_o.gt_start      = (rd_data_q > start_pos);
  assign sts_o.split_zero    = (split_q == '0);
  assign sts_o.split_eq_cnt  = (split_q == count_q);
  assign sts_o.slot_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_pos_o   = head_q;
  assign out_sum_o   = sum_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== design/sds_ctrl.sv =====
// ----------------------------------------------------------------------------
// SCAN disk scheduler controller
// Sequences sorted insertion, split search and the two sweeps around the
// disk edge, driving the datapath through a command bundle.
// ----------------------------------------------------------------------------
module sds_ctrl import sds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INS_CHK = 11'b000_0000_0010,
    S_INS_CMP = 11'b000_0000_0100,
    S_SPL_CHK = 11'b000_0000_1000,
    S_SPL_CMP = 11'b000_0001_0000,
    S_START   = 11'b000_0010_0000,
    S_SW1_CHK = 11'b000_0100_0000,
    S_SW1_VIS = 11'b000_1000_0000,
    S_EDGE    = 11'b001_0000_0000,
    S_SW2_CHK = 11'b010_0000_0000,
    S_SW2_VIS = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    fin     = 1'b0;
    cmd_o   = '{default: '0, ptr_op: PTR_HOLD, vis_sel: VIS_DATA};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          last_d        = in_last_i;
          if (!sts_i.full) begin
            cmd_o.ptr_op = PTR_CNT;
            state_d      = S_INS_CHK;
          end else if (in_last_i) begin
            cmd_o.ptr_op = PTR_ZERO;
            state_d      = S_SPL_CHK;
          end
        end
      end
      S_INS_CHK: begin
        if (sts_i.ptr_zero) begin
          cmd_o.wr_req = 1'b1;
          cmd_o.ptr_op = last_q ? PTR_ZERO : PTR_HOLD;
          state_d      = last_q ? S_SPL_CHK : S_IDLE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.gt_req) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.ptr_op   = PTR_DEC;
          state_d        = S_INS_CHK;
        end else begin
          cmd_o.wr_req = 1'b1;
          cmd_o.ptr_op = last_q ? PTR_ZERO : PTR_HOLD;
          state_d      = last_q ? S_SPL_CHK : S_IDLE;
        end
      end
      S_SPL_CHK: begin
        if (sts_i.ptr_eq_cnt) begin
          cmd_o.save_split = 1'b1;
          state_d          = S_START;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SPL_CMP;
        end
      end
      S_SPL_CMP: begin
        if (sts_i.gt_start) begin
          cmd_o.save_split = 1'b1;
          state_d          = S_START;
        end else begin
          cmd_o.ptr_op = PTR_INC;
          state_d      = S_SPL_CHK;
        end
      end
      S_START: begin
        if (sts_i.slot_free) begin
          cmd_o.vis_en  = 1'b1;
          cmd_o.vis_sel = VIS_START;
          cmd_o.ptr_op  = PTR_SPLIT;
          state_d       = S_SW1_CHK;
        end
      end
      S_SW1_CHK: begin
        if (sts_i.dir_up ? sts_i.ptr_eq_cnt : sts_i.ptr_zero) begin
          state_d = S_EDGE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = !sts_i.dir_up;
          state_d       = S_SW1_VIS;
        end
      end
      S_SW1_VIS: begin
        if (sts_i.slot_free) begin
          cmd_o.vis_en = 1'b1;
          cmd_o.ptr_op = sts_i.dir_up ? PTR_INC : PTR_DEC;
          state_d      = S_SW1_CHK;
        end
      end
      S_EDGE: begin
        if (sts_i.slot_free) begin
          fin            = sts_i.dir_up ? sts_i.split_zero : sts_i.split_eq_cnt;
          cmd_o.vis_en   = 1'b1;
          cmd_o.vis_sel  = VIS_EDGE;
          cmd_o.vis_last = fin;
          cmd_o.ptr_op   = PTR_SPLIT;
          cmd_o.clr_count = fin;
          state_d        = fin ? S_IDLE : S_SW2_CHK;
        end
      end
      S_SW2_CHK: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_prev = sts_i.dir_up;
        state_d       = S_SW2_VIS;
      end
      S_SW2_VIS: begin
        if (sts_i.slot_free) begin
          fin             = sts_i.dir_up ? sts_i.ptr_one : sts_i.ptr_eq_cnt_m1;
          cmd_o.vis_en    = 1'b1;
          cmd_o.vis_last  = fin;
          cmd_o.clr_count = fin;
          cmd_o.ptr_op    = sts_i.dir_up ? PTR_DEC : PTR_INC;
          state_d         = fin ? S_IDLE : S_SW2_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/scan_disk_scheduler.sv =====
// ----------------------------------------------------------------------------
// SCAN disk scheduler
// Loads a job of cylinder requests into a sorted store and walks the
// elevator order from the configured head, reporting each head position.
// ----------------------------------------------------------------------------
// One request word is taken at a time; tlast closes the job. A request is
// inserted into the sorted store by reading and shifting up each stored entry
// larger than it, then writing it into the freed slot.
// The closing word then scans for the split point and emits n + 2 result
// words (start, each request, edge), paced by the memory read ahead of each
// visit and by m_axis back-pressure. No new request is taken until the last
// result is loaded into the output register. A request arriving with the
// store full is dropped, and its tlast still starts the schedule.
module scan_disk_scheduler import sds_pkg::*; #(
  parameter int MAX_REQUESTS = 32,
  parameter int CYL_BITS     = 16,
  localparam int InW  = ((CYL_BITS + 7) / 8) * 8,
  localparam int OutW = ((2 * CYL_BITS + 1 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InW-1:0]      s_axis_tdata,   // request_cylinder
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutW-1:0]     m_axis_tdata,   // position, total_movement
  output logic                m_axis_tlast
);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [CYL_BITS-1:0] out_pos;
  logic [CYL_BITS:0]   out_sum;

  sds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sds_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .CYL_BITS     (CYL_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (s_axis_tdata[CYL_BITS-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pos_o   (out_pos),
    .out_sum_o   (out_sum),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OutW - 2 * CYL_BITS - 1){1'b0}}, out_sum, out_pos};

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.vis_en |-> sts.slot_free)
    else $error("result word loaded while output register still held");

  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.vis_en && !cmd.wr_shift)
    else $error("datapath active while taking requests");

  a_shift_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_shift |-> !sts.ptr_zero)
    else $error("insertion shift below entry zero");

  a_last_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.vis_en && cmd.vis_last |=> s_axis_tready && m_axis_tvalid && m_axis_tlast)
    else $error("final word did not return the scheduler to idle");

endmodule

// ===== test/scan_disk_scheduler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler checker
// Tracks configuration writes and request words, builds the expected seek
// sequence for every closed job and compares each result word against it.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_checker import sds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [15:0]         s_data_i,    // request_cylinder
  input  logic                s_last_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [39:0]         m_data_i,    // position, total_movement
  input  logic                m_last_i,
  output int                  errors_o,
  output int                  pending_o
);

  localparam int          Depth   = 32;
  localparam logic [16:0] MoveMax = 17'h1FFFF;

  typedef struct packed {
    logic [15:0] pos;
    logic [16:0] moved;
    logic        fin;
  } seek_t;

  logic [16:0] disk_size_q;
  logic [15:0] head_start_q;
  logic        dir_up_q;
  logic [15:0] sorted_reqs [Depth];
  int          held;
  logic [15:0] head_now;
  logic [16:0] moved_sum;
  seek_t       seeks_due [$];

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors_o++;
    $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic visit(input logic [15:0] pos);
    int unsigned step;
    int unsigned total;
    seek_t       s;
    step = (pos > head_now) ? int'(pos - head_now) : int'(head_now - pos);
    total = moved_sum + step;
    moved_sum = (total > MoveMax) ? MoveMax : total[16:0];
    head_now = pos;
    s.pos = pos;
    s.moved = moved_sum;
    s.fin = 1'b0;
    seeks_due.push_back(s);
  endtask

  task automatic run_schedule();
    logic [15:0] edge_hi;
    int          split;
    if (disk_size_q == '0) begin
      edge_hi = '0;
    end else if (disk_size_q > 17'd65535) begin
      edge_hi = 16'hFFFF;
    end else begin
      edge_hi = disk_size_q[15:0] - 16'd1;
    end
    split = held;
    for (int i = 0; i < held; i++) begin
      if (split == held && sorted_reqs[i] > head_start_q) split = i;
    end
    head_now = head_start_q;
    moved_sum = '0;
    visit(head_start_q);
    if (dir_up_q) begin
      for (int i = split; i < held; i++) visit(sorted_reqs[i]);
      visit(edge_hi);
      for (int i = split - 1; i >= 0; i--) visit(sorted_reqs[i]);
    end else begin
      for (int i = split - 1; i >= 0; i--) visit(sorted_reqs[i]);
      visit(16'd0);
      for (int i = split; i < held; i++) visit(sorted_reqs[i]);
    end
    seeks_due[seeks_due.size() - 1].fin = 1'b1;
    held = 0;
  endtask

  task automatic load_request(input logic [15:0] req, input logic fin);
    int p;
    // drop the word when the store is full
    if (held < Depth) begin
      p = held;
      while (p > 0 && sorted_reqs[p - 1] > req) begin
        sorted_reqs[p] = sorted_reqs[p - 1];
        p--;
      end
      sorted_reqs[p] = req;
      held++;
    end
    if (fin) run_schedule();
  endtask

  task automatic check_word();
    seek_t want;
    if (seeks_due.size() == 0) begin
      report_mismatch("result word with none due", m_data_i[15:0], 0);
    end else begin
      want = seeks_due.pop_front();
      if (m_data_i[15:0] !== want.pos) begin
        report_mismatch("position", m_data_i[15:0], want.pos);
      end
      if (m_data_i[32:16] !== want.moved) begin
        report_mismatch("total_movement", m_data_i[32:16], want.moved);
      end
      if (m_last_i !== want.fin) report_mismatch("tlast", m_last_i, want.fin);
      if (m_data_i[39:33] !== '0) report_mismatch("tdata padding", m_data_i[39:33], 0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_size_q = DISK_SIZE_RST;
      head_start_q = HEAD_START_RST;
      dir_up_q = DIRECTION_UP_RST;
      held = 0;
      head_now = '0;
      moved_sum = '0;
      seeks_due.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DISK_SIZE:    disk_size_q = cfg_data_i;
          CFG_HEAD_START:   head_start_q = cfg_data_i[15:0];
          CFG_DIRECTION_UP: dir_up_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) load_request(s_data_i, s_last_i);
      if (m_valid_i && m_ready_i) check_word();
      pending_o = seeks_due.size();
    end
  end

endmodule

// ===== test/scan_disk_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler testbench
// Drives directed and random request jobs under several configurations and
// idling patterns; the checker predicts every seek word and counts mismatches.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_tb;
  import sds_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx       = CFG_DISK_SIZE;
  logic [CfgDataW-1:0] cfg_data      = '0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;   // request_cylinder
  logic                s_axis_tlast  = 1'b0;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  wire  [39:0]         m_axis_tdata;         // position, total_movement
  wire                 m_axis_tlast;

  int          errors;
  int          pending;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic        hold_req      = 1'b0;
  int          hold_left     = 0;
  int          words_sent    = 0;
  logic [15:0] cur_head      = HEAD_START_RST;
  logic [16:0] cur_size      = DISK_SIZE_RST;

  scan_disk_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  scan_disk_scheduler_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_last_i   (s_axis_tlast),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .m_last_i   (m_axis_tlast),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("scan_disk_scheduler_tb: errors");
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic [15:0] cyl, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cyl;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_job(input logic [15:0] cyls [$]);
    foreach (cyls[i]) send_word(cyls[i], i == cyls.size() - 1);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic configure(input logic [16:0] size, input logic [16:0] head_word,
                           input logic up);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_DISK_SIZE;
    cfg_data <= size;
    @(negedge clk_i);
    cfg_idx <= CFG_HEAD_START;
    cfg_data <= head_word;
    @(negedge clk_i);
    cfg_idx <= CFG_DIRECTION_UP;
    cfg_data <= {16'($urandom), up};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_size = size;
    cur_head = head_word[15:0];
  endtask

  function automatic logic [15:0] pick_cylinder();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return cur_head;
      3:       return cur_head + 16'($urandom_range(8)) - 16'd4;
      4:       return cur_size[15:0] - 16'd1;
      5, 6:    return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_setting();
    logic [16:0] size;
    logic [16:0] head;
    case ($urandom_range(7))
      0:       size = 17'd0;
      1:       size = 17'd1;
      2:       size = 17'd65535;
      3:       size = 17'd65536;
      4:       size = 17'h1FFFF;
      5:       size = 17'd200;
      default: size = 17'($urandom);
    endcase
    case ($urandom_range(3))
      0:       head = {1'($urandom), 16'd0};
      1:       head = {1'($urandom), 16'hFFFF};
      2:       head = 17'($urandom_range(300));
      default: head = 17'($urandom);
    endcase
    configure(size, head, 1'($urandom));
  endtask

  task automatic random_job();
    logic [15:0] cyls [$];
    int          len;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 4) begin
      len = $urandom_range(36, 33);
    end else if (roll < 14) begin
      len = $urandom_range(32, 9);
    end else begin
      len = $urandom_range(8, 1);
    end
    repeat (len) cyls.push_back(pick_cylinder());
    send_job(cyls);
  endtask

  initial begin
    int goal;
    int jobs;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_job('{16'd0});
    send_job('{16'hFFFF, 16'd150, 16'd7});
    configure(17'd200, 17'd100, 1'b0);
    send_job('{16'd100, 16'd50, 16'd150, 16'd100, 16'd0});
    configure(17'd0, 17'h0FFFF, 1'b1);
    send_job('{16'hFFFF, 16'd0, 16'd300});
    configure(17'd1, 17'd30000, 1'b1);
    send_job('{16'hFFFF, 16'd30000, 16'd0});
    configure(17'h1FFFF, 17'h1FFFF, 1'b0);
    send_job('{16'hFFFF, 16'd1, 16'hFFFE});

    jobs = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          send_idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      goal = words_sent + 100;
      while (words_sent < goal) begin
        if (jobs != 3 && $urandom_range(3) == 0) random_setting();
        random_job();
        if (jobs == 2) hold_req = 1'b1;
        jobs++;
      end
    end

    settle();
    repeat (50) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("scan_disk_scheduler_tb: clean");
    end else begin
      $display("scan_disk_scheduler_tb: errors");
    end
    $finish;
  end

endmodule
